// ===== design/pmsc_pkg.sv =====
// shared types and constants of the pid motion settle controller
// no dependencies; imported by pid_motion_settle_controller
`default_nettype none

package pmsc_pkg;

    // finish after this many consecutive in-band ticks
    localparam int SETTLE_TICKS   = 20;
    // fraction bits of the pid gains
    localparam int GAIN_FRAC_BITS = 8;

    localparam int FIELD_W   = 24;
    localparam int DRIVE_W   = 15;
    localparam int BAND_W    = 23;
    localparam int GAIN_W    = 16;
    localparam int TICKS_W   = 16;
    localparam int INTEG_W   = 32;
    localparam int BCOUNT_W  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;

    // heading circle in 1/16 degree
    localparam int HEADING_FULL = 5760;
    localparam int HEADING_HALF = 2880;
    // 5760 = 45 * 128: the low 7 bits pass through, the rest is reduced mod 45
    localparam int HEAD_LOW_W   = 7;
    localparam int HEAD_ODD     = 45;
    // multiple of 5760 that lifts any 24 bit signed value to a positive one
    localparam int HEAD_OFFSET  = 5760 * 1457;
    // ceil(2^24 / 45), exact for quotients of values below 2^18
    localparam int RECIP_SHIFT  = 24;
    localparam int HEAD_RECIP   = 372828;

    localparam int DRIVE_NEG_MAX = 16383;

    typedef enum logic [1:0] {
        KIND_LATERAL     = 2'd0,
        KIND_TURN        = 2'd1,
        KIND_SWING_RIGHT = 2'd2,
        KIND_SWING_LEFT  = 2'd3
    } motion_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_DRIVE_MAX     = 3'd3,
        REG_DRIVE_MIN     = 3'd4,
        REG_INTEGRAL_BAND = 3'd5,
        REG_SETTLE_BAND   = 3'd6,
        REG_TIMEOUT_TICKS = 3'd7
    } cfg_reg_t;

    // finish flags carried from the state stage to the output
    typedef struct packed {
        logic run;
        logic done;
        logic tmo;
    } tick_status_t;

endpackage

`default_nettype wire

// ===== design/pid_motion_settle_controller.sv =====
// pid motion settle controller: error forming, integral and settle state,
// pid products, clamp and drive routing; depends on pmsc_pkg
`default_nettype none

// Use: one beat on the input channel per control tick (restart, motion_kind,
// setpoint, pos_a, pos_b); exactly one result beat comes back per tick, in
// order, with left_drive, right_drive, error_now, done_res and timed_out.
// Gains, clamps, bands and the timeout are written through the cfg port
// while no tick is in flight.
// Throughput is one tick per cycle while the output does not stall: the
// tick state (integral, last error, band count, elapsed time, finished
// flag) is read and rewritten in a single stage, and the heading modulo
// and the three gain products sit in stages of their own.
// Each stage holds one beat and moves as soon as the stage after it is free,
// so input beats are taken while a result waits; in_stall rises only once
// all seven stages are full behind a stalled output.
// Reset clears the pipeline, the tick state, and loads the default config
// (zero gains, +-12000 mV clamps, bands 15 and 32, timeout 400 ticks).
module pid_motion_settle_controller (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pmsc_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              restart,
    input  wire logic [1:0]                        motion_kind,
    input  wire logic signed [pmsc_pkg::FIELD_W-1:0] setpoint,
    input  wire logic signed [pmsc_pkg::FIELD_W-1:0] pos_a,
    input  wire logic signed [pmsc_pkg::FIELD_W-1:0] pos_b,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [pmsc_pkg::DRIVE_W-1:0]    left_drive,
    output logic signed [pmsc_pkg::DRIVE_W-1:0]    right_drive,
    output logic signed [pmsc_pkg::FIELD_W-1:0]    error_now,
    output logic                                   done_res,
    output logic                                   timed_out
);
    import pmsc_pkg::*;

    localparam int NSTAGE = 7;
    localparam int QW     = 12;
    localparam int VW     = 18;
    localparam int PW     = VW + RECIP_SHIFT - 5;
    localparam int HW     = 13;
    localparam int DW     = 14;
    localparam int PP_W   = GAIN_W + 1 + FIELD_W;
    localparam int PI_W   = GAIN_W + 1 + INTEG_W;
    localparam int PD_W   = GAIN_W + 1 + FIELD_W + 1;
    localparam int SUM_W  = PI_W;
    localparam int O_W    = SUM_W - GAIN_FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DRIVE_W-1:0] drive_max_reg, drive_min_reg;
    logic [BAND_W-1:0]         integral_band_reg, settle_band_reg;
    logic [TICKS_W-1:0]        timeout_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= '0;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            drive_max_reg     <= DRIVE_W'(12000);
            drive_min_reg     <= DRIVE_W'(-12000);
            integral_band_reg <= BAND_W'(15);
            settle_band_reg   <= BAND_W'(32);
            timeout_ticks_reg <= TICKS_W'(400);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:        gain_p_reg        <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:        gain_i_reg        <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:        gain_d_reg        <= cfg_data[GAIN_W-1:0];
                REG_DRIVE_MAX:     drive_max_reg     <= cfg_data[DRIVE_W-1:0];
                REG_DRIVE_MIN:     drive_min_reg     <= cfg_data[DRIVE_W-1:0];
                REG_INTEGRAL_BAND: integral_band_reg <= cfg_data[BAND_W-1:0];
                REG_SETTLE_BAND:   settle_band_reg   <= cfg_data[BAND_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TICKS_W-1:0];
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic [NSTAGE:1]   vld_reg, vld_next;
    logic [NSTAGE+1:1] rdy;
    logic [NSTAGE:1]   ld;

    always_comb
    begin
        rdy[NSTAGE+1] = !out_stall;
        for (int k = NSTAGE; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        for (int k = 1; k <= NSTAGE; k++)
        begin
            if (k == 1)
            begin
                vld_next[k] = rdy[k] ? in_valid : vld_reg[k];
                ld[k]       = rdy[k] && in_valid;
            end
            else
            begin
                vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
                ld[k]       = rdy[k] && vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[1];
    assign out_valid = vld_reg[NSTAGE];

    // ---------------- stage 1: input register ----------------
    logic                      s1_restart_reg;
    motion_kind_t              s1_kind_reg;
    logic signed [FIELD_W-1:0] s1_sp_reg, s1_pa_reg, s1_pb_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s1_restart_reg <= restart;
            s1_kind_reg    <= motion_kind_t'(motion_kind);
            s1_sp_reg      <= setpoint;
            s1_pa_reg      <= pos_a;
            s1_pb_reg      <= pos_b;
        end
    end

    // ---------------- stage 2: lateral error, heading quotients ----------------
    logic signed [FIELD_W:0]   lat_sum, lat_diff;
    logic signed [FIELD_W-1:0] lat_mean, lat_err;
    logic [FIELD_W:0]          ua, us;
    logic [VW-1:0]             va, vs;
    logic [PW-1:0]             prod_a, prod_s;

    always_comb
    begin
        lat_sum  = {s1_pa_reg[FIELD_W-1], s1_pa_reg} + {s1_pb_reg[FIELD_W-1], s1_pb_reg};
        lat_mean = lat_sum[FIELD_W:1];
        lat_diff = {s1_sp_reg[FIELD_W-1], s1_sp_reg} - {lat_mean[FIELD_W-1], lat_mean};
        if (lat_diff[FIELD_W] != lat_diff[FIELD_W-1])
        begin
            lat_err = lat_diff[FIELD_W] ? {1'b1, {(FIELD_W-1){1'b0}}}
                                        : {1'b0, {(FIELD_W-1){1'b1}}};
        end
        else
        begin
            lat_err = lat_diff[FIELD_W-1:0];
        end
        ua     = {s1_pa_reg[FIELD_W-1], s1_pa_reg} + (FIELD_W+1)'(HEAD_OFFSET);
        us     = {s1_sp_reg[FIELD_W-1], s1_sp_reg} + (FIELD_W+1)'(HEAD_OFFSET);
        va     = ua[FIELD_W:HEAD_LOW_W];
        vs     = us[FIELD_W:HEAD_LOW_W];
        prod_a = PW'(va) * PW'(HEAD_RECIP);
        prod_s = PW'(vs) * PW'(HEAD_RECIP);
    end

    logic                      s2_restart_reg;
    motion_kind_t              s2_kind_reg;
    logic signed [FIELD_W-1:0] s2_lat_reg;
    logic [VW-1:0]             s2_va_reg, s2_vs_reg;
    logic [QW-1:0]             s2_qa_reg, s2_qs_reg;
    logic [HEAD_LOW_W-1:0]     s2_la_reg, s2_ls_reg;

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            s2_restart_reg <= s1_restart_reg;
            s2_kind_reg    <= s1_kind_reg;
            s2_lat_reg     <= lat_err;
            s2_va_reg      <= va;
            s2_vs_reg      <= vs;
            s2_qa_reg      <= prod_a[RECIP_SHIFT+QW-1:RECIP_SHIFT];
            s2_qs_reg      <= prod_s[RECIP_SHIFT+QW-1:RECIP_SHIFT];
            s2_la_reg      <= ua[HEAD_LOW_W-1:0];
            s2_ls_reg      <= us[HEAD_LOW_W-1:0];
        end
    end

    // ---------------- stage 3: heading wrap and error select ----------------
    logic [VW-1:0]             rem_a, rem_s;
    logic [HW-1:0]             h_a, h_s;
    logic signed [DW-1:0]      hd0, hd1, hd2;
    logic signed [FIELD_W-1:0] err_sel;

    always_comb
    begin
        rem_a = s2_va_reg - VW'(s2_qa_reg) * VW'(HEAD_ODD);
        rem_s = s2_vs_reg - VW'(s2_qs_reg) * VW'(HEAD_ODD);
        h_a   = {rem_a[5:0], s2_la_reg};
        h_s   = {rem_s[5:0], s2_ls_reg};
        hd0   = $signed({1'b0, h_s}) - $signed({1'b0, h_a});
        hd1   = hd0[DW-1] ? hd0 + DW'(HEADING_FULL) : hd0;
        hd2   = (hd1 > DW'(HEADING_HALF)) ? hd1 - DW'(HEADING_FULL) : hd1;
        if (s2_kind_reg == KIND_LATERAL)
        begin
            err_sel = s2_lat_reg;
        end
        else
        begin
            err_sel = FIELD_W'(hd2);
        end
    end

    logic                      s3_restart_reg;
    motion_kind_t              s3_kind_reg;
    logic signed [FIELD_W-1:0] s3_err_reg;

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            s3_restart_reg <= s2_restart_reg;
            s3_kind_reg    <= s2_kind_reg;
            s3_err_reg     <= err_sel;
        end
    end

    // ---------------- stage 4: tick state update ----------------
    logic signed [INTEG_W-1:0] integral_sum_reg, integral_sum_next;
    logic signed [FIELD_W-1:0] last_error_reg, last_error_next;
    logic [BCOUNT_W-1:0]       band_count_reg, band_count_next;
    logic [TICKS_W-1:0]        elapsed_reg, elapsed_next;
    logic                      finished_reg, finished_next;

    logic signed [INTEG_W-1:0] int_eff;
    logic signed [FIELD_W-1:0] last_eff;
    logic [BCOUNT_W-1:0]       band_eff;
    logic [TICKS_W-1:0]        elapsed_eff;
    logic                      fin_eff;
    logic                      tmo_hit;
    logic [FIELD_W-1:0]        abs_e;
    logic signed [INTEG_W:0]   int_add;
    logic signed [FIELD_W:0]   err_diff;
    logic                      sign_flip;
    tick_status_t              status;
    logic                      state_move;

    assign state_move = vld_reg[3] && rdy[4];

    always_comb
    begin
        int_eff     = s3_restart_reg ? '0 : integral_sum_reg;
        last_eff    = s3_restart_reg ? '0 : last_error_reg;
        band_eff    = s3_restart_reg ? '0 : band_count_reg;
        elapsed_eff = s3_restart_reg ? '0 : elapsed_reg;
        fin_eff     = s3_restart_reg ? 1'b0 : finished_reg;

        tmo_hit   = (timeout_ticks_reg != '0) && (elapsed_eff >= timeout_ticks_reg);
        abs_e     = s3_err_reg[FIELD_W-1] ? FIELD_W'(-s3_err_reg) : FIELD_W'(s3_err_reg);
        int_add   = {int_eff[INTEG_W-1], int_eff}
                  + {{(INTEG_W-FIELD_W+1){s3_err_reg[FIELD_W-1]}}, s3_err_reg};
        err_diff  = {s3_err_reg[FIELD_W-1], s3_err_reg} - {last_eff[FIELD_W-1], last_eff};
        sign_flip = (s3_err_reg < 0 && last_eff > 0) || (s3_err_reg > 0 && last_eff < 0);

        integral_sum_next = int_eff;
        last_error_next   = last_eff;
        band_count_next   = band_eff;
        elapsed_next      = elapsed_eff;
        finished_next     = fin_eff;
        status            = '{run: 1'b0, done: 1'b1, tmo: 1'b0};

        priority if (fin_eff)
        begin
            status.tmo = tmo_hit;
        end
        else if (tmo_hit)
        begin
            finished_next = 1'b1;
            status.tmo    = 1'b1;
        end
        else if (band_eff >= BCOUNT_W'(SETTLE_TICKS))
        begin
            finished_next = 1'b1;
        end
        else
        begin
            status = '{run: 1'b1, done: 1'b0, tmo: 1'b0};
            if (abs_e < {1'b0, integral_band_reg})
            begin
                if (int_add[INTEG_W] != int_add[INTEG_W-1])
                begin
                    integral_sum_next = int_add[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                                         : {1'b0, {(INTEG_W-1){1'b1}}};
                end
                else
                begin
                    integral_sum_next = int_add[INTEG_W-1:0];
                end
            end
            if (s3_err_reg == '0 || sign_flip)
            begin
                integral_sum_next = '0;
            end
            last_error_next = s3_err_reg;
            if (abs_e < {1'b0, settle_band_reg})
            begin
                if (band_eff != '1)
                begin
                    band_count_next = band_eff + 1'b1;
                end
            end
            else
            begin
                band_count_next = '0;
            end
            if (elapsed_eff != '1)
            begin
                elapsed_next = elapsed_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
            band_count_reg   <= '0;
            elapsed_reg      <= '0;
            finished_reg     <= 1'b0;
        end
        else if (state_move)
        begin
            integral_sum_reg <= integral_sum_next;
            last_error_reg   <= last_error_next;
            band_count_reg   <= band_count_next;
            elapsed_reg      <= elapsed_next;
            finished_reg     <= finished_next;
        end
    end

    motion_kind_t              s4_kind_reg;
    logic signed [FIELD_W-1:0] s4_err_reg;
    logic signed [INTEG_W-1:0] s4_int_reg;
    logic signed [FIELD_W:0]   s4_diff_reg;
    tick_status_t              s4_status_reg;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            s4_kind_reg   <= s3_kind_reg;
            s4_err_reg    <= s3_err_reg;
            s4_int_reg    <= integral_sum_next;
            s4_diff_reg   <= err_diff;
            s4_status_reg <= status;
        end
    end

    // ---------------- stage 5: gain products ----------------
    logic signed [PP_W-1:0] prod_p;
    logic signed [PI_W-1:0] prod_i;
    logic signed [PD_W-1:0] prod_d;

    always_comb
    begin
        prod_p = PP_W'($signed({1'b0, gain_p_reg})) * PP_W'(s4_err_reg);
        prod_i = PI_W'($signed({1'b0, gain_i_reg})) * PI_W'(s4_int_reg);
        prod_d = PD_W'($signed({1'b0, gain_d_reg})) * PD_W'(s4_diff_reg);
    end

    motion_kind_t              s5_kind_reg;
    logic signed [FIELD_W-1:0] s5_err_reg;
    tick_status_t              s5_status_reg;
    logic signed [PP_W-1:0]    s5_p_reg;
    logic signed [PI_W-1:0]    s5_i_reg;
    logic signed [PD_W-1:0]    s5_d_reg;

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            s5_kind_reg   <= s4_kind_reg;
            s5_err_reg    <= s4_err_reg;
            s5_status_reg <= s4_status_reg;
            s5_p_reg      <= prod_p;
            s5_i_reg      <= prod_i;
            s5_d_reg      <= prod_d;
        end
    end

    // ---------------- stage 6: sum and scale ----------------
    logic signed [SUM_W-1:0] pid_sum;

    // dropping the fraction bits of a two's complement sum rounds toward minus infinity
    assign pid_sum = SUM_W'(s5_p_reg) + s5_i_reg + SUM_W'(s5_d_reg);

    motion_kind_t              s6_kind_reg;
    logic signed [FIELD_W-1:0] s6_err_reg;
    tick_status_t              s6_status_reg;
    logic signed [O_W-1:0]     s6_out_reg;

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            s6_kind_reg   <= s5_kind_reg;
            s6_err_reg    <= s5_err_reg;
            s6_status_reg <= s5_status_reg;
            s6_out_reg    <= pid_sum[SUM_W-1:GAIN_FRAC_BITS];
        end
    end

    // ---------------- stage 7: clamp, route, output register ----------------
    logic signed [O_W-1:0]     clamp_hi, clamp_lo;
    logic signed [DRIVE_W-1:0] drv, drv_neg;
    logic signed [DRIVE_W-1:0] left_sel, right_sel;

    always_comb
    begin
        // min clamp last so it wins when the limits cross
        clamp_hi = (s6_out_reg > O_W'(drive_max_reg)) ? O_W'(drive_max_reg) : s6_out_reg;
        clamp_lo = (clamp_hi < O_W'(drive_min_reg)) ? O_W'(drive_min_reg) : clamp_hi;
        drv      = clamp_lo[DRIVE_W-1:0];
        drv_neg  = (drv == {1'b1, {(DRIVE_W-1){1'b0}}}) ? DRIVE_W'(DRIVE_NEG_MAX) : -drv;
        left_sel  = '0;
        right_sel = '0;
        if (s6_status_reg.run)
        begin
            unique case (s6_kind_reg)
                KIND_LATERAL:
                begin
                    left_sel  = drv;
                    right_sel = drv;
                end
                KIND_TURN:
                begin
                    left_sel  = drv;
                    right_sel = drv_neg;
                end
                KIND_SWING_RIGHT:
                begin
                    right_sel = drv;
                end
                KIND_SWING_LEFT:
                begin
                    left_sel  = drv;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            left_drive  <= left_sel;
            right_drive <= right_sel;
            error_now   <= s6_err_reg;
            done_res    <= s6_status_reg.done;
            timed_out   <= s6_status_reg.tmo;
        end
    end

`ifndef SYNTHESIS
    a_done_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> left_drive == '0 && right_drive == '0)
        else $error("finished tick drives the motors");

    a_timeout_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> done_res)
        else $error("timeout flagged on a running tick");

    a_restart_runs: assert property (@(posedge clk) disable iff (!rst_n)
        state_move && s3_restart_reg |=> elapsed_reg == TICKS_W'(1) && !finished_reg)
        else $error("restart tick did not start a fresh motion");

    a_free_stage_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> !in_stall)
        else $error("input stalled with an empty stage");
`endif

endmodule

`default_nettype wire

// ===== dv/pid_motion_settle_controller_tb.sv =====
// self-checking testbench of the pid motion settle controller: directed and
// random control ticks, random idling on both channels, config phases
// depends on pmsc_pkg and pid_motion_settle_controller
module pid_motion_settle_controller_tb;

    import pmsc_pkg::*;

    localparam int     PIPE_DEPTH  = 7;
    localparam int     CYCLE_LIMIT = 600000;
    localparam longint FIELD_HI    = 8388607;
    localparam longint FIELD_LO    = -8388608;
    localparam longint INTEG_HI    = (longint'(1) <<< 31) - 1;
    localparam longint INTEG_LO    = -(longint'(1) <<< 31);
    localparam int     PHASES      = 11;

    typedef enum int {
        PROF_DIRECTED,
        PROF_MODERATE,
        PROF_MAX_GAIN,
        PROF_INVERTED,
        PROF_WINDUP,
        PROF_SHORT_TIMEOUT,
        PROF_RANDOM
    } profile_t;

    typedef struct packed {
        logic                        restart;
        motion_kind_t                kind;
        logic signed [FIELD_W-1:0]   setpoint;
        logic signed [FIELD_W-1:0]   pos_a;
        logic signed [FIELD_W-1:0]   pos_b;
    } tick_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]   left;
        logic signed [DRIVE_W-1:0]   right;
        logic signed [FIELD_W-1:0]   err;
        logic                        done;
        logic                        tmo;
    } drive_cmd_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_we      = 1'b0;
    cfg_reg_t                     cfg_index   = REG_GAIN_P;
    logic [CFG_DAT_W-1:0]         cfg_data    = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic                         restart     = 1'b0;
    motion_kind_t                 motion_kind = KIND_LATERAL;
    logic signed [FIELD_W-1:0]    setpoint    = '0;
    logic signed [FIELD_W-1:0]    pos_a       = '0;
    logic signed [FIELD_W-1:0]    pos_b       = '0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic signed [DRIVE_W-1:0]    left_drive;
    logic signed [DRIVE_W-1:0]    right_drive;
    logic signed [FIELD_W-1:0]    error_now;
    logic                         done_res;
    logic                         timed_out;

    // predictor copy of the config registers, reset values
    longint kp = 0, ki = 0, kd = 0;
    longint dmax = 12000, dmin = -12000;
    longint iband = 15, sband = 32, tmo_lim = 400;

    // predictor copy of the motion state
    longint integ_acc   = 0;
    longint prev_err    = 0;
    int     band_run    = 0;
    int     ticks_run   = 0;
    bit     motion_over = 1'b0;

    tick_t      pending[$];
    drive_cmd_t result_q[$];
    tick_t      cur_tick;
    drive_cmd_t want;
    bit         offering  = 1'b0;
    bit         send_idle = 1'b1;
    bit         recv_idle = 1'b1;
    int         send_gap  = 0;
    int         recv_wait = 0;
    int         hold_left = 0;

    int ticks_sent   = 0;
    int results_seen = 0;
    int done_seen    = 0;
    int tmo_seen     = 0;
    int held_cycles  = 0;
    int mismatches   = 0;
    int cycles       = 0;

    pid_motion_settle_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .motion_kind (motion_kind),
        .setpoint    (setpoint),
        .pos_a       (pos_a),
        .pos_b       (pos_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .error_now   (error_now),
        .done_res    (done_res),
        .timed_out   (timed_out)
    );

    always #6 clk = ~clk;

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint rand24();
        logic signed [FIELD_W-1:0] v;
        v = FIELD_W'($urandom);
        return v;
    endfunction

    function automatic tick_t make_tick(bit rs, motion_kind_t k, longint sp, longint pa,
                                        longint pb);
        tick_t t;
        t.restart  = rs;
        t.kind     = k;
        t.setpoint = sp[FIELD_W-1:0];
        t.pos_a    = pa[FIELD_W-1:0];
        t.pos_b    = pb[FIELD_W-1:0];
        return t;
    endfunction

    // one control tick of the pid law, updates the predictor state
    function automatic drive_cmd_t pid_tick(tick_t t);
        longint     sp, pa, pb, e, h, d, o, l, r;
        bit         hit;
        drive_cmd_t res;
        sp = t.setpoint;
        pa = t.pos_a;
        pb = t.pos_b;
        l  = 0;
        r  = 0;
        res = '0;
        if (t.restart) begin
            integ_acc   = 0;
            prev_err    = 0;
            band_run    = 0;
            ticks_run   = 0;
            motion_over = 1'b0;
        end
        if (t.kind == KIND_LATERAL) begin
            e = clip(sp - ((pa + pb) >>> 1), FIELD_LO, FIELD_HI);
        end
        else begin
            // heading difference wrapped into (-180, +180] degrees
            h = pa % HEADING_FULL;
            if (h < 0)
                h += HEADING_FULL;
            d = (sp - h) % HEADING_FULL;
            if (d < 0)
                d += HEADING_FULL;
            if (d > HEADING_HALF)
                d -= HEADING_FULL;
            e = d;
        end
        hit = (tmo_lim != 0) && (ticks_run >= tmo_lim);
        if (motion_over) begin
            res.done = 1'b1;
            res.tmo  = hit;
        end
        else if (hit) begin
            motion_over = 1'b1;
            res.done    = 1'b1;
            res.tmo     = 1'b1;
        end
        else if (band_run >= SETTLE_TICKS) begin
            motion_over = 1'b1;
            res.done    = 1'b1;
        end
        else begin
            if (mag(e) < iband)
                integ_acc = clip(integ_acc + e, INTEG_LO, INTEG_HI);
            if (e == 0 || (e < 0 && prev_err > 0) || (e > 0 && prev_err < 0))
                integ_acc = 0;
            o = kp * e + ki * integ_acc + kd * (e - prev_err);
            o = o >>> GAIN_FRAC_BITS;
            if (o > dmax)
                o = dmax;
            // min clamp last so it wins over an inverted max
            if (o < dmin)
                o = dmin;
            prev_err = e;
            if (mag(e) < sband) begin
                if (band_run < 63)
                    band_run++;
            end
            else begin
                band_run = 0;
            end
            if (ticks_run < 65535)
                ticks_run++;
            case (t.kind)
                KIND_LATERAL: begin
                    l = o;
                    r = o;
                end
                KIND_TURN: begin
                    l = o;
                    r = clip(-o, -DRIVE_NEG_MAX - 1, DRIVE_NEG_MAX);
                end
                KIND_SWING_RIGHT: begin
                    l = 0;
                    r = o;
                end
                default: begin
                    l = o;
                    r = 0;
                end
            endcase
        end
        res.left  = l[DRIVE_W-1:0];
        res.right = r[DRIVE_W-1:0];
        res.err   = e[FIELD_W-1:0];
        return res;
    endfunction

    task automatic write_reg(cfg_reg_t idx, longint v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_DAT_W-1:0];
        case (idx)
            REG_GAIN_P:        kp      = v & 16'hFFFF;
            REG_GAIN_I:        ki      = v & 16'hFFFF;
            REG_GAIN_D:        kd      = v & 16'hFFFF;
            REG_DRIVE_MAX:     dmax    = $signed(v[DRIVE_W-1:0]);
            REG_DRIVE_MIN:     dmin    = $signed(v[DRIVE_W-1:0]);
            REG_INTEGRAL_BAND: iband   = v & 23'h7FFFFF;
            REG_SETTLE_BAND:   sband   = v & 23'h7FFFFF;
            default:           tmo_lim = v & 16'hFFFF;
        endcase
    endtask

    task automatic program_profile(profile_t p);
        longint g_p, g_i, g_d, hi, lo, ib, sb, tl;
        g_p = $urandom_range(64, 1024);
        g_i = $urandom_range(0, 64);
        g_d = $urandom_range(0, 512);
        hi  = 12000;
        lo  = -12000;
        ib  = $urandom_range(4, 200);
        sb  = $urandom_range(8, 64);
        tl  = 400;
        case (p)
            PROF_DIRECTED: begin
                g_p = 512;
                g_i = 32;
                g_d = 128;
                ib  = 100;
                sb  = 32;
            end
            PROF_MAX_GAIN: begin
                g_p = 65535;
                g_i = 65535;
                g_d = 65535;
                ib  = 8388607;
                sb  = 8388607;
                tl  = 65535;
            end
            PROF_INVERTED: begin
                // min above max: every running tick drives drive_min
                hi = -12000;
                lo = 12000;
                ib = 0;
                sb = 0;
                tl = $urandom_range(30, 60);
            end
            PROF_WINDUP: begin
                g_i = $urandom_range(1, 16);
                hi  = $urandom_range(0, 12000);
                lo  = -longint'($urandom_range(0, 12000));
                ib  = 8388607;
                sb  = 0;
                tl  = 0;
            end
            PROF_SHORT_TIMEOUT: begin
                sb = $urandom_range(0, 4);
                tl = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 25);
            end
            PROF_RANDOM: begin
                g_p = $urandom_range(0, 65535);
                g_i = $urandom_range(0, 65535);
                g_d = $urandom_range(0, 65535);
                hi  = longint'($urandom_range(0, 24000)) - 12000;
                lo  = longint'($urandom_range(0, 24000)) - 12000;
                ib  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607)
                                                  : $urandom_range(0, 300);
                sb  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607)
                                                  : $urandom_range(0, 300);
                tl  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
            end
            default: ;
        endcase
        write_reg(REG_GAIN_P, g_p);
        write_reg(REG_GAIN_I, g_i);
        write_reg(REG_GAIN_D, g_d);
        write_reg(REG_DRIVE_MAX, hi);
        write_reg(REG_DRIVE_MIN, lo);
        write_reg(REG_INTEGRAL_BAND, ib);
        write_reg(REG_SETTLE_BAND, sb);
        write_reg(REG_TIMEOUT_TICKS, tl);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // a motion that converges on its target, with overshoot and jitter
    task automatic gen_motion(int len, bit fresh);
        motion_kind_t k;
        longint       sp, err, mean, delta, pa, pb;
        k = motion_kind_t'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       err = $urandom_range(0, 40);
            1:       err = $urandom_range(0, 2000);
            2:       err = $urandom_range(0, 200000);
            default: err = rand24();
        endcase
        if ($urandom_range(0, 1))
            err = -err;
        if (k == KIND_LATERAL) begin
            sp = ($urandom_range(0, 3) == 0) ? rand24()
                                             : longint'($urandom_range(0, 10000)) - 5000;
        end
        else begin
            sp = ($urandom_range(0, 3) == 0) ? rand24() : $urandom_range(0, HEADING_FULL - 1);
            err = err % HEADING_HALF;
        end
        for (int t = 0; t < len; t++) begin
            if (k == KIND_LATERAL) begin
                mean  = sp - err;
                delta = longint'($urandom_range(0, 60)) - 30;
                pa    = clip(mean + delta + $urandom_range(0, 1), FIELD_LO, FIELD_HI);
                pb    = clip(mean - delta, FIELD_LO, FIELD_HI);
            end
            else begin
                pa = sp - err + HEADING_FULL * (longint'($urandom_range(0, 4)) - 2);
                pa = clip(pa, FIELD_LO, FIELD_HI);
                pb = rand24();
            end
            pending.push_back(make_tick(fresh && t == 0, k, sp, pa, pb));
            if ($urandom_range(0, 15) == 0)
                err = -(err / 2);
            else
                err = (err * 3) / 4;
            if (mag(err) < 8)
                err = longint'($urandom_range(0, 4)) - 2;
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || offering || result_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    // sender: offers the head of the pending queue, random gaps between beats
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            restart     <= 1'b0;
            motion_kind <= KIND_LATERAL;
            setpoint    <= '0;
            pos_a       <= '0;
            pos_b       <= '0;
            offering    = 1'b0;
            send_gap    = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                result_q.push_back(pid_tick(cur_tick));
                ticks_sent++;
                offering = 1'b0;
                send_gap = send_idle ? $urandom_range(0, 11) : 0;
                if ($urandom_range(0, 49) == 0)
                    send_idle = !send_idle;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                else if (pending.size() > 0) begin
                    cur_tick = pending.pop_front();
                    offering = 1'b1;
                end
            end
            in_valid    <= offering;
            restart     <= cur_tick.restart;
            motion_kind <= cur_tick.kind;
            setpoint    <= cur_tick.setpoint;
            pos_a       <= cur_tick.pos_a;
            pos_b       <= cur_tick.pos_b;
        end
    end

    // receiver: checks each result beat, random stalls and a few long hold-offs
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (done_res)
                    done_seen++;
                if (timed_out)
                    tmo_seen++;
                if (result_q.size() == 0) begin
                    $error("result beat with no tick in flight: left_drive %0d error_now %0d",
                           left_drive, error_now);
                    mismatches++;
                end
                else begin
                    want = result_q.pop_front();
                    if (left_drive !== want.left) begin
                        $error("left_drive: expected %0d, got %0d", want.left, left_drive);
                        mismatches++;
                    end
                    if (right_drive !== want.right) begin
                        $error("right_drive: expected %0d, got %0d", want.right, right_drive);
                        mismatches++;
                    end
                    if (error_now !== want.err) begin
                        $error("error_now: expected %0d, got %0d", want.err, error_now);
                        mismatches++;
                    end
                    if (done_res !== want.done) begin
                        $error("done_res: expected %0d, got %0d", want.done, done_res);
                        mismatches++;
                    end
                    if (timed_out !== want.tmo) begin
                        $error("timed_out: expected %0d, got %0d", want.tmo, timed_out);
                        mismatches++;
                    end
                end
                recv_wait = recv_idle ? $urandom_range(0, 11) : 0;
                if ($urandom_range(0, 49) == 0)
                    recv_idle = !recv_idle;
                // long hold-off so the pipeline fills and stalls the input
                if (results_seen % 700 == 350)
                    hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0) begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (in_valid && in_stall)
            held_cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pid_motion_settle_controller_tb: FAIL");
            $finish;
        end
    end

    initial begin
        profile_t plan[PHASES];
        int       n;
        int       len;
        plan = '{PROF_MODERATE, PROF_MAX_GAIN, PROF_SHORT_TIMEOUT, PROF_INVERTED,
                 PROF_RANDOM, PROF_WINDUP, PROF_SHORT_TIMEOUT, PROF_MODERATE,
                 PROF_RANDOM, PROF_MAX_GAIN, PROF_INVERTED};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // a few ticks on the reset config, no restart beat first
        gen_motion(8, 1'b0);
        drain();

        program_profile(PROF_DIRECTED);
        pending.push_back(make_tick(1'b1, KIND_LATERAL, 0, 0, 0));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, FIELD_HI, FIELD_LO, FIELD_LO));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, FIELD_LO, FIELD_HI, FIELD_HI));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, 0, -3, 0));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, 5, 2, 1));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, 10, 0, 0));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, 10, 0, 0));
        pending.push_back(make_tick(1'b0, KIND_LATERAL, -50, 0, 0));
        pending.push_back(make_tick(1'b1, KIND_TURN, HEADING_HALF, 0, FIELD_HI));
        pending.push_back(make_tick(1'b0, KIND_TURN, 0, HEADING_HALF, FIELD_LO));
        pending.push_back(make_tick(1'b0, KIND_TURN, HEADING_HALF + 1, 0, 0));
        pending.push_back(make_tick(1'b0, KIND_TURN, 0, -1, 0));
        pending.push_back(make_tick(1'b0, KIND_TURN, FIELD_HI, FIELD_LO, FIELD_HI));
        pending.push_back(make_tick(1'b0, KIND_TURN, -4000, 4000, 0));
        pending.push_back(make_tick(1'b1, KIND_SWING_RIGHT, 100, HEADING_FULL * 3 + 10, -1));
        pending.push_back(make_tick(1'b0, KIND_SWING_RIGHT, 0, FIELD_HI, 0));
        pending.push_back(make_tick(1'b1, KIND_SWING_LEFT, FIELD_LO, FIELD_HI, 0));
        pending.push_back(make_tick(1'b0, KIND_SWING_LEFT, 3000, 100, -1));
        pending.push_back(make_tick(1'b0, KIND_SWING_LEFT, 100, 3000, FIELD_LO));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            program_profile(plan[ph]);
            if (plan[ph] == PROF_WINDUP) begin
                // same-sign error just inside the band drives the integral to its limits
                for (int t = 0; t < 270; t++) begin
                    n = $urandom_range(0, 3);
                    pending.push_back(make_tick(t == 0, KIND_LATERAL, FIELD_HI, 1 + n, 1 + n));
                end
                for (int t = 0; t < 270; t++) begin
                    n = $urandom_range(0, 3);
                    pending.push_back(make_tick(t == 0, KIND_LATERAL, FIELD_LO, -2 - n,
                                                -2 - n));
                end
            end
            else begin
                n = 0;
                while (n < 100) begin
                    if ($urandom_range(0, 7) == 0) begin
                        pending.push_back(make_tick($urandom_range(0, 7) == 0,
                                                    motion_kind_t'($urandom_range(0, 3)),
                                                    rand24(), rand24(), rand24()));
                        n++;
                    end
                    else begin
                        len = $urandom_range(5, 60);
                        // first motion of a phase carries on from the held state
                        gen_motion(len, (n != 0) && ($urandom_range(0, 6) != 0));
                        n += len;
                    end
                end
            end
            drain();
        end

        $display("ran %0d ticks through %0d config phases, %0d results checked",
                 ticks_sent, PHASES + 2, results_seen);
        $display("%0d finished-motion results, %0d by timeout, %0d cycles of input stall",
                 done_seen, tmo_seen, held_cycles);
        if (mismatches == 0)
            $display("pid_motion_settle_controller_tb: PASS");
        else
            $display("pid_motion_settle_controller_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pmsc_pkg.sv
design/pid_motion_settle_controller.sv
dv/pid_motion_settle_controller_tb.sv
